// ===== hdl/nrn_pkg.sv =====
`timescale 1ns / 1ps

package nrn_pkg;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SCALE      = 3'd4,
    REG_OFFSET     = 3'd5
  } reg_index_t;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int CHAN_W  = 16;
  localparam int COORD_W = 10;
  localparam int SRC_CFG_W = 9;
  localparam int DST_CFG_W = 11;

  // Depth of the request queue between front and back end (power of two)
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic              is_req;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } item_t;

endpackage

// ===== hdl/nrn_front.sv =====
`timescale 1ns / 1ps

module nrn_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            mode,
  input  logic [nrn_pkg::BYTE_W-1:0]      red,
  input  logic [nrn_pkg::BYTE_W-1:0]      green,
  input  logic [nrn_pkg::BYTE_W-1:0]      blue,
  input  logic                            q_pop,
  output logic                            q_empty,
  output nrn_pkg::item_t                  q_item
);

  localparam int PW = $clog2(nrn_pkg::QDEPTH);

  nrn_pkg::item_t slots [nrn_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           push_ok;
  logic           pop_ok;
  nrn_pkg::item_t in_item;

  assign full    = (count == (PW+1)'(nrn_pkg::QDEPTH));
  assign q_empty = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = q_pop && !q_empty;
  assign q_item  = slots[rd_ptr];

  // classify: mode high is an output request, low a source pixel load
  always_comb begin
    in_item.is_req = mode;
    in_item.red    = red;
    in_item.green  = green;
    in_item.blue   = blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== hdl/nrn_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module nrn_divider #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] steps;
  logic             busy;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // quot doubles as the numerator shift register
  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = (trial >= {1'b0, denom});
  assign diff  = trial - {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= numer;
    end else if (busy) begin
      rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/nrn_back.sv =====
`timescale 1ns / 1ps

module nrn_back #(
  parameter int MAX_SRC_DIM = 256,
  parameter int MAX_DST_DIM = 1024,
  parameter int SDW = 9,
  parameter int DDW = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  // request queue
  input  logic                              q_empty,
  input  nrn_pkg::item_t                    q_item,
  output logic                              q_pop,
  // clamped dimensions and channel constants
  input  logic [SDW-1:0]                    sw,
  input  logic [SDW-1:0]                    sh,
  input  logic [DDW-1:0]                    dw,
  input  logic [DDW-1:0]                    dh,
  input  logic [3*nrn_pkg::CHAN_W-1:0]      scale_pack,
  input  logic [3*nrn_pkg::CHAN_W-1:0]      offset_pack,
  // results
  output logic                              empty,
  input  logic                              pop,
  output logic signed [nrn_pkg::CHAN_W-1:0] chan_red,
  output logic signed [nrn_pkg::CHAN_W-1:0] chan_green,
  output logic signed [nrn_pkg::CHAN_W-1:0] chan_blue,
  output logic [nrn_pkg::COORD_W-1:0]       out_col,
  output logic [nrn_pkg::COORD_W-1:0]       out_row,
  output logic                              frame_end
);

  localparam int SAW   = $clog2(MAX_SRC_DIM);
  localparam int AW    = 2 * SAW;
  localparam int DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int SAD   = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(MAX_DST_DIM);
  localparam int NW    = CW + SDW;
  localparam int PIX_W = 3 * nrn_pkg::BYTE_W;
  localparam int PRD_W = nrn_pkg::BYTE_W + nrn_pkg::CHAN_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MULT   = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_ADDR   = 7'b0001000,
    S_READ   = 7'b0010000,
    S_NORM   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t            state;
  logic [CW-1:0]     col_cnt;
  logic [CW-1:0]     row_cnt;
  logic [LW-1:0]     load_count;
  logic [2*SDW-1:0]  load_limit;
  logic              store_we;
  logic [PIX_W-1:0]  frame_store [DEPTH];
  logic [PIX_W-1:0]  store_q;
  logic [SAD-1:0]    addr_q;
  logic [NW-1:0]     prod_x;
  logic [NW-1:0]     prod_y;
  logic              div_start;
  logic              div_done_x;
  logic              div_done_y;
  logic [NW-1:0]     quot_x;
  logic [NW-1:0]     quot_y;
  logic [SAW-1:0]    sx;
  logic [SAW-1:0]    sy;
  logic [AW-1:0]     addr_sum;
  logic [PRD_W-1:0]  prod_r;
  logic [PRD_W-1:0]  prod_g;
  logic [PRD_W-1:0]  prod_b;
  logic              out_valid;
  logic              finish_go;
  logic              col_last;
  logic              row_last;

  function automatic logic signed [nrn_pkg::CHAN_W-1:0] norm_chan(
    input logic [PRD_W-1:0]           p,
    input logic [nrn_pkg::CHAN_W-1:0] off
  );
    logic [PRD_W:0]      rounded;
    logic signed [17:0]  v;
    logic signed [nrn_pkg::CHAN_W-1:0] r;
    // round half up from 2^-20 to Q4.12, then subtract the offset
    rounded = {1'b0, p} + (PRD_W+1)'(128);
    v = $signed({2'b00, rounded[PRD_W-1:8]}) - $signed({{2{off[15]}}, off});
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign q_pop      = (state == S_IDLE) && !q_empty;
  assign load_limit = (2*SDW)'(sw) * (2*SDW)'(sh);
  assign store_we   = q_pop && !q_item.is_req && (32'(load_count) < 32'(load_limit));
  assign div_start  = (state == S_MULT);
  assign empty      = !out_valid;
  assign finish_go  = (state == S_FINISH) && (!out_valid || pop);
  assign col_last   = (32'(col_cnt) + 32'd1 >= 32'(dw));
  assign row_last   = (32'(row_cnt) + 32'd1 >= 32'(dh));

  // source coordinate, clamped to the last row/column of the source frame
  always_comb begin
    sx = (32'(quot_x) > 32'(sw) - 32'd1) ? SAW'(32'(sw) - 32'd1) : SAW'(quot_x);
    sy = (32'(quot_y) > 32'(sh) - 32'd1) ? SAW'(32'(sh) - 32'd1) : SAW'(quot_y);
    addr_sum = AW'(sy) * AW'(sw) + AW'(sx);
  end

  nrn_divider #(.NUM_W(NW), .DEN_W(DDW)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (prod_x),
    .denom (dw),
    .done  (div_done_x),
    .quot  (quot_x)
  );

  nrn_divider #(.NUM_W(NW), .DEN_W(DDW)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (prod_y),
    .denom (dh),
    .done  (div_done_y),
    .quot  (quot_y)
  );

  // frame store
  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_store[SAD'(load_count)] <= {q_item.blue, q_item.green, q_item.red};
    end
    store_q <= frame_store[addr_q];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      col_cnt    <= '0;
      row_cnt    <= '0;
      load_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (store_we) begin
        load_count <= load_count + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (q_pop && q_item.is_req) begin
            state <= S_MULT;
          end
        end
        S_MULT: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done_x) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_NORM;
        end
        S_NORM: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (finish_go) begin
            state <= S_IDLE;
            if (col_last) begin
              col_cnt <= '0;
              if (row_last) begin
                row_cnt    <= '0;
                load_count <= '0;
              end else begin
                row_cnt <= row_cnt + 1'b1;
              end
            end else begin
              col_cnt <= col_cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_x <= NW'(col_cnt) * NW'(sw);
      prod_y <= NW'(row_cnt) * NW'(sh);
    end
    if (state == S_ADDR) begin
      addr_q <= SAD'(addr_sum);
    end
    if (state == S_NORM) begin
      prod_r <= PRD_W'(store_q[7:0])   * PRD_W'(scale_pack[15:0]);
      prod_g <= PRD_W'(store_q[15:8])  * PRD_W'(scale_pack[31:16]);
      prod_b <= PRD_W'(store_q[23:16]) * PRD_W'(scale_pack[47:32]);
    end
    if (finish_go) begin
      chan_red   <= norm_chan(prod_r, offset_pack[15:0]);
      chan_green <= norm_chan(prod_g, offset_pack[31:16]);
      chan_blue  <= norm_chan(prod_b, offset_pack[47:32]);
      out_col    <= nrn_pkg::COORD_W'(col_cnt);
      out_row    <= nrn_pkg::COORD_W'(row_cnt);
      frame_end  <= col_last && row_last;
    end
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    div_done_x == div_done_y)
    else $error("row and column dividers out of step");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done_x |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(chan_red) && $stable(out_col)
                             && $stable(frame_end)))
    else $error("waiting result changed before it was taken");

  a_frame_rewind: assert property (@(posedge clk) disable iff (rst)
    (finish_go && col_last && row_last) |=>
      (col_cnt == '0 && row_cnt == '0 && load_count == '0))
    else $error("frame end did not rewind counters");

endmodule

// ===== hdl/nearest_resize_normalize.sv =====
`timescale 1ns / 1ps
// Loads: one per cycle while the back end is idle; a pushed load waits in the queue
// until then. Output requests, one at a time: products, coordinate division, address,
// frame store read, channel multiply and output register; the bit-serial coordinate
// dividers give one quotient bit per cycle. A 4-entry queue decouples input.
// Reset (rst, synchronous): queue, raster counters and load count cleared, registers
// back to defaults; frame store contents undefined until loaded.

module nearest_resize_normalize #(
  parameter int MAX_SRC_DIM = 256,
  parameter int MAX_DST_DIM = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_en,
  input  logic [nrn_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [nrn_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input requests
  input  logic                                push,
  output logic                                full,
  input  logic                                mode,
  input  logic [nrn_pkg::BYTE_W-1:0]          red,
  input  logic [nrn_pkg::BYTE_W-1:0]          green,
  input  logic [nrn_pkg::BYTE_W-1:0]          blue,
  // results
  output logic                                empty,
  input  logic                                pop,
  output logic signed [nrn_pkg::CHAN_W-1:0]   chan_red,
  output logic signed [nrn_pkg::CHAN_W-1:0]   chan_green,
  output logic signed [nrn_pkg::CHAN_W-1:0]   chan_blue,
  output logic [nrn_pkg::COORD_W-1:0]         out_col,
  output logic [nrn_pkg::COORD_W-1:0]         out_row,
  output logic                                frame_end
);

  // widths that hold a dimension up to its maximum
  localparam int SDW = $clog2(MAX_SRC_DIM + 1);
  localparam int DDW = $clog2(MAX_DST_DIM + 1);

  // configuration registers, as written
  logic [nrn_pkg::SRC_CFG_W-1:0]    src_width;
  logic [nrn_pkg::SRC_CFG_W-1:0]    src_height;
  logic [nrn_pkg::DST_CFG_W-1:0]    dst_width;
  logic [nrn_pkg::DST_CFG_W-1:0]    dst_height;
  logic [3*nrn_pkg::CHAN_W-1:0]     scale_pack;
  logic [3*nrn_pkg::CHAN_W-1:0]     offset_pack;

  // dimensions clamped to [1, max]
  logic [SDW-1:0] sw;
  logic [SDW-1:0] sh;
  logic [DDW-1:0] dw;
  logic [DDW-1:0] dh;

  logic           q_pop;
  logic           q_empty;
  nrn_pkg::item_t q_item;

  // Configuration writes land immediately. The user must write only while the block is
  // idle, so the back end never sees a register change mid-request; this is not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= nrn_pkg::SRC_CFG_W'(256);
      src_height  <= nrn_pkg::SRC_CFG_W'(256);
      dst_width   <= nrn_pkg::DST_CFG_W'(512);
      dst_height  <= nrn_pkg::DST_CFG_W'(512);
      scale_pack  <= 48'h1010_1010_1010;
      offset_pack <= '0;
    end else if (cfg_en) begin
      case (cfg_addr)
        nrn_pkg::REG_SRC_WIDTH:  src_width   <= cfg_data[nrn_pkg::SRC_CFG_W-1:0];
        nrn_pkg::REG_SRC_HEIGHT: src_height  <= cfg_data[nrn_pkg::SRC_CFG_W-1:0];
        nrn_pkg::REG_DST_WIDTH:  dst_width   <= cfg_data[nrn_pkg::DST_CFG_W-1:0];
        nrn_pkg::REG_DST_HEIGHT: dst_height  <= cfg_data[nrn_pkg::DST_CFG_W-1:0];
        nrn_pkg::REG_SCALE:      scale_pack  <= cfg_data[3*nrn_pkg::CHAN_W-1:0];
        nrn_pkg::REG_OFFSET:     offset_pack <= cfg_data[3*nrn_pkg::CHAN_W-1:0];
        default: begin
          // writes to unused indexes are dropped
        end
      endcase
    end
  end

  // Out-of-range dimensions: zero reads as one, too large reads as the maximum.
  always_comb begin
    sw = (src_width == '0) ? SDW'(1) :
         (32'(src_width) > MAX_SRC_DIM) ? SDW'(MAX_SRC_DIM) : SDW'(src_width);
    sh = (src_height == '0) ? SDW'(1) :
         (32'(src_height) > MAX_SRC_DIM) ? SDW'(MAX_SRC_DIM) : SDW'(src_height);
    dw = (dst_width == '0) ? DDW'(1) :
         (32'(dst_width) > MAX_DST_DIM) ? DDW'(MAX_DST_DIM) : DDW'(dst_width);
    dh = (dst_height == '0) ? DDW'(1) :
         (32'(dst_height) > MAX_DST_DIM) ? DDW'(MAX_DST_DIM) : DDW'(dst_height);
  end

  // Front end: takes each request (load or output) pushed while not full, in order, into a short queue.
  nrn_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .mode    (mode),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_item  (q_item)
  );

  // Back end: stores loads, walks the destination raster, maps each output
  // pixel to its source pixel by exact integer division, normalizes the three
  // channels and holds the result in an output register until popped.
  nrn_back #(
    .MAX_SRC_DIM (MAX_SRC_DIM),
    .MAX_DST_DIM (MAX_DST_DIM),
    .SDW         (SDW),
    .DDW         (DDW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .sw          (sw),
    .sh          (sh),
    .dw          (dw),
    .dh          (dh),
    .scale_pack  (scale_pack),
    .offset_pack (offset_pack),
    .empty       (empty),
    .pop         (pop),
    .chan_red    (chan_red),
    .chan_green  (chan_green),
    .chan_blue   (chan_blue),
    .out_col     (out_col),
    .out_row     (out_row),
    .frame_end   (frame_end)
  );

endmodule
